[sv/frs_pkg.sv]
// Shared types, constants and helpers for the fire row stencil.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package frs_pkg;

    localparam int HEAT_W = 4;
    localparam int COL_W  = 10;
    localparam int RND_W  = 2;

    // Output queue
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;
    localparam int Q_CW    = 3;

    // Register map, index taken from paddr[2]
    localparam logic REG_MODE = 1'b0;

    // Mode codes
    localparam logic MODE_AVERAGE = 1'b0;
    localparam logic MODE_HOTTEST = 1'b1;

    typedef logic [HEAT_W-1:0] t_heat;
    typedef logic [COL_W-1:0]  t_col;
    typedef logic [RND_W-1:0]  t_rnd;

    typedef struct packed {
        t_heat heat;
        t_col  col;
        logic  row_end;
    } t_result;

    // Up to two results handed to the queue in one cycle
    typedef struct packed {
        logic [1:0] cnt;
        t_result    first;
        t_result    second;
    } t_push;

    // Divide by three for values up to 46: multiply by 43, drop 7 bits
    function automatic t_heat div3(input logic [5:0] v);
        logic [11:0] p;
        p = {6'b0, v} * 12'd43;
        return p[10:7];
    endfunction

endpackage

[sv/frs_kernel.sv]
// Stencil arithmetic for one inner output cell from the three cells below it.
// Depends on frs_pkg.
`timescale 1ns / 1ps

module frs_kernel #(
    parameter int HEAT_CEILING = 8
) (
    input  frs_pkg::t_heat i_left,
    input  frs_pkg::t_heat i_middle,
    input  frs_pkg::t_heat i_right,
    input  frs_pkg::t_rnd  i_rnd,
    input  logic           i_mode,
    output frs_pkg::t_heat o_cell
);
    import frs_pkg::*;

    localparam t_heat CEIL = t_heat'(HEAT_CEILING);

    t_heat      hot;
    t_heat      decayed;
    logic [5:0] sum;

    always_comb begin
        hot = i_left;
        if (i_middle > hot) hot = i_middle;
        if (i_right > hot) hot = i_right;
        decayed = (hot > t_heat'(i_rnd)) ? hot - t_heat'(i_rnd) : '0;
        if (decayed > CEIL) decayed = CEIL;

        sum = 6'(i_left) + 6'(i_middle) + 6'(i_right) + 6'(i_rnd[0]);

        o_cell = (i_mode == MODE_HOTTEST) ? decayed : div3(sum);
    end

endmodule

[sv/frs_queue.sv]
// Four-entry result queue; takes up to two results a cycle, gives one.
// Depends on frs_pkg.
`timescale 1ns / 1ps

module frs_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  frs_pkg::t_push      i_push,
    input  logic                i_pop,
    output logic [frs_pkg::Q_CW-1:0] o_count,
    output logic                o_valid,
    output frs_pkg::t_result    o_head
);
    import frs_pkg::*;

    t_result         r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr, n_wr;
    logic [Q_AW-1:0] r_rd, n_rd;
    logic [Q_CW-1:0] r_count, n_count;
    logic [Q_AW-1:0] wr_next;

    assign wr_next = r_wr + Q_AW'(1);

    always_comb begin
        n_wr    = r_wr + Q_AW'(i_push.cnt);
        n_rd    = r_rd + Q_AW'(i_pop);
        n_count = r_count + Q_CW'(i_push.cnt) - Q_CW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) r_mem[r_wr] <= i_push.first;
        if (i_push.cnt == 2'd2) r_mem[wr_next] <= i_push.second;
    end

    assign o_count = r_count;
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd];

endmodule

[sv/fire_row_stencil.sv]
// Fire row stencil: takes one source cell per transfer, in column order, and gives the
// new row above it, one cell per output transfer. It sustains one input transfer per
// clock while the queue has room; results pass the input register, then the queue. The
// item for column 1 gives nothing and the item for the last column gives two results;
// a four-entry queue behind the single output port absorbs the extra edge cell.
// Depends on frs_pkg, frs_kernel and frs_queue.
`timescale 1ns / 1ps

module fire_row_stencil #(
    parameter int ROW_WIDTH    = 120,
    parameter int HEAT_CEILING = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // source cells
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  frs_pkg::t_heat        i_cell_value,
    input  frs_pkg::t_rnd         i_random_bits,
    // new row
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output frs_pkg::t_heat        o_new_cell,
    output frs_pkg::t_col         o_out_column,
    output logic                  o_row_end,
    // register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import frs_pkg::*;

    localparam t_col COL_LAST = t_col'(ROW_WIDTH - 1);

    // Register port
    logic r_mode;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MODE) ? {31'b0, r_mode} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_AVERAGE;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_MODE) begin
            r_mode <= pwdata[0];
        end
    end

    // Row tracking, advanced on every input transfer
    t_col  r_col;
    t_heat r_left;
    t_heat r_middle;
    logic  in_accept;

    // Input register
    logic  r_s1_valid;
    t_col  r_s1_col;
    t_heat r_s1_left;
    t_heat r_s1_middle;
    t_heat r_s1_right;
    t_rnd  r_s1_rnd;

    logic [Q_CW-1:0] q_count;
    logic [Q_CW-1:0] q_space;
    logic            s1_fire;
    t_heat           inner;
    t_push           push;
    t_result         head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_left   <= '0;
            r_middle <= '0;
        end else if (in_accept) begin
            r_col    <= (r_col == COL_LAST) ? '0 : r_col + t_col'(1);
            r_left   <= r_middle;
            r_middle <= i_cell_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_col    <= r_col;
            r_s1_left   <= r_left;
            r_s1_middle <= r_middle;
            r_s1_right  <= i_cell_value;
            r_s1_rnd    <= i_random_bits;
        end
    end

    frs_kernel #(
        .HEAT_CEILING (HEAT_CEILING)
    ) u_kernel (
        .i_left   (r_s1_left),
        .i_middle (r_s1_middle),
        .i_right  (r_s1_right),
        .i_rnd    (r_s1_rnd),
        .i_mode   (r_mode),
        .o_cell   (inner)
    );

    // Results of the held item: column 0 is an edge, column 1 gives nothing,
    // later columns give the inner cell to their left, the last also its own edge.
    always_comb begin
        push.first.heat    = inner;
        push.first.col     = r_s1_col - t_col'(1);
        push.first.row_end = 1'b0;
        if (r_s1_col == '0) begin
            push.first.heat = '0;
            push.first.col  = '0;
        end
        push.second.heat    = '0;
        push.second.col     = r_s1_col;
        push.second.row_end = 1'b1;

        if (r_s1_col == t_col'(1)) push.cnt = 2'd0;
        else if (r_s1_col == COL_LAST) push.cnt = 2'd2;
        else push.cnt = 2'd1;

        q_space = Q_CW'(Q_DEPTH) - q_count;
        s1_fire = r_s1_valid && (q_space >= Q_CW'(push.cnt));
        if (!s1_fire) push.cnt = 2'd0;
    end

    assign o_in_stall = r_s1_valid && !s1_fire;
    assign in_accept  = i_in_valid && !o_in_stall;

    frs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (o_out_valid && !i_out_stall),
        .o_count (q_count),
        .o_valid (o_out_valid),
        .o_head  (head)
    );

    assign o_new_cell   = head.heat;
    assign o_out_column = head.col;
    assign o_row_end    = head.row_end;

endmodule

[sv/frs_checker.sv]
// Port-level checks for the fire row stencil, bound to the top level.
// Depends on frs_pkg and fire_row_stencil.
`timescale 1ns / 1ps

module frs_checker #(
    parameter int ROW_WIDTH = 120
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input frs_pkg::t_heat        o_new_cell,
    input frs_pkg::t_col         o_out_column,
    input logic                  o_row_end
);
    import frs_pkg::*;

    localparam t_col COL_LAST = t_col'(ROW_WIDTH - 1);

    // nothing comes out straight after reset
    a_quiet_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output transfer offered right after reset");

    // row end marks the last column, which is an edge cell
    a_row_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_row_end |-> o_out_column == COL_LAST && o_new_cell == '0)
        else $error("row end on wrong column or non-zero edge");

    // the first column is an edge and never ends the row
    a_left_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_column == '0 |-> o_new_cell == '0 && !o_row_end)
        else $error("left edge cell not zero");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_new_cell)
            && $stable(o_out_column) && $stable(o_row_end))
        else $error("stalled result changed");

endmodule

bind fire_row_stencil frs_checker #(
    .ROW_WIDTH (ROW_WIDTH)
) u_frs_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_new_cell   (o_new_cell),
    .o_out_column (o_out_column),
    .o_row_end    (o_row_end)
);

[sim/tb_fire_row_stencil.sv]
// Self-checking testbench for fire_row_stencil: directed rows, then random rows in phases
// of alternating mode, checked transfer by transfer against an in-bench row predictor.
// Depends on frs_pkg and the fire_row_stencil RTL.
`timescale 1ns / 1ps

module tb_fire_row_stencil;
    import frs_pkg::*;

    localparam int ROW_WIDTH     = 120;
    localparam int HEAT_CEILING  = 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 6;
    localparam int RANDOM_ITEMS  = 700;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_heat       i_cell_value = '0;
    t_rnd        i_random_bits = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_heat       o_new_cell;
    t_col        o_out_column;
    logic        o_row_end;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // predictor state
    t_col    src_col = '0;
    t_heat   cell_left = '0;
    t_heat   cell_mid = '0;
    logic    fire_mode = MODE_AVERAGE;
    t_result expected_cells[$];

    int  error_count = 0;
    int  cycle_count = 0;
    bit  no_idle = 1'b0;

    fire_row_stencil #(
        .ROW_WIDTH    (ROW_WIDTH),
        .HEAT_CEILING (HEAT_CEILING)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_cell_value  (i_cell_value),
        .i_random_bits (i_random_bits),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_new_cell    (o_new_cell),
        .o_out_column  (o_out_column),
        .o_row_end     (o_row_end),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timed out with %0d cells outstanding", $time, expected_cells.size());
            $display("fire_row_stencil regression: fail");
            $finish;
        end
    end

    function automatic t_heat stencil_heat(input t_heat a, input t_heat b, input t_heat c,
                                           input t_rnd rnd);
        int hot;
        int v;
        if (fire_mode == MODE_HOTTEST) begin
            hot = a;
            if (b > hot) hot = b;
            if (c > hot) hot = c;
            v = (hot > rnd) ? hot - rnd : 0;
            if (v > HEAT_CEILING) v = HEAT_CEILING;
        end else begin
            v = (int'(a) + int'(b) + int'(c) + int'(rnd[0])) / 3;
        end
        return t_heat'(v);
    endfunction

    task automatic push_cell(input t_heat heat, input t_col col, input logic row_end);
        t_result r;
        r.heat    = heat;
        r.col     = col;
        r.row_end = row_end;
        expected_cells.push_back(r);
    endtask

    // One source cell: edge at column 0, nothing at column 1, column c-1 otherwise,
    // plus the far edge cell when the row closes.
    task automatic predict_row_step(input t_heat src_heat, input t_rnd rnd);
        if (src_col == 0)
            push_cell('0, '0, 1'b0);
        else if (src_col >= 2)
            push_cell(stencil_heat(cell_left, cell_mid, src_heat, rnd), src_col - 1'b1, 1'b0);
        if (int'(src_col) + 1 >= ROW_WIDTH) begin
            push_cell('0, src_col, 1'b1);
            src_col = '0;
        end else begin
            src_col = src_col + 1'b1;
        end
        cell_left = cell_mid;
        cell_mid  = src_heat;
    endtask

    always @(posedge i_clk) begin : row_checker
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_cells.size() == 0) begin
                $display("%0t: unexpected cell: heat %0d column %0d row_end %0b",
                         $time, o_new_cell, o_out_column, o_row_end);
                error_count++;
            end else begin
                want = expected_cells.pop_front();
                if (o_new_cell !== want.heat) begin
                    $display("%0t: column %0d heat: expected %0d, got %0d",
                             $time, want.col, want.heat, o_new_cell);
                    error_count++;
                end
                if (o_out_column !== want.col) begin
                    $display("%0t: column: expected %0d, got %0d",
                             $time, want.col, o_out_column);
                    error_count++;
                end
                if (o_row_end !== want.row_end) begin
                    $display("%0t: column %0d row_end: expected %0b, got %0b",
                             $time, want.col, want.row_end, o_row_end);
                    error_count++;
                end
            end
        end
    end

    // Output side: random stall before each transfer
    initial begin : out_stall_gen
        int n;
        forever begin
            n = no_idle ? 0 : $urandom_range(0, 11);
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
        end
    end

    task automatic send_cell(input t_heat src_heat, input t_rnd rnd);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_cell_value  <= src_heat;
        i_random_bits <= rnd;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        predict_row_step(src_heat, rnd);
    endtask

    // Hold off input until every expected cell has come out, then let the pipe settle
    task automatic drain_rows;
        i_in_valid <= 1'b0;
        while (expected_cells.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic m);
        drain_rows();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_MODE, 2'b00};
        pwdata  <= {31'b0, m};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        fire_mode = m;
        // read back
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (prdata !== 32'(m)) begin
            $display("%0t: mode readback: expected %0d, got %0h", $time, m, prdata);
            error_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic t_heat draw_heat;
        case ($urandom_range(0, 3))
            0:       return t_heat'($urandom_range(HEAT_CEILING - 2, 15));
            1:       return t_heat'($urandom_range(0, 3));
            default: return t_heat'($urandom_range(0, 15));
        endcase
    endfunction

    // Average mode from the start of a row: full heat, bit 1 of the decay ignored
    task automatic test_average_extremes;
        write_mode(MODE_AVERAGE);
        send_cell(4'd15, 2'd3);
        send_cell(4'd15, 2'd0);
        send_cell(4'd15, 2'd1);
        send_cell(4'd0,  2'd3);
        send_cell(4'd0,  2'd0);
        send_cell(4'd0,  2'd1);
        send_cell(4'd15, 2'd2);
        send_cell(4'd0,  2'd1);
    endtask

    // Switched mid row: clamp to the ceiling, decay past zero, values under the ceiling
    task automatic test_hottest_decay;
        write_mode(MODE_HOTTEST);
        send_cell(4'd15, 2'd0);
        send_cell(4'd15, 2'd0);
        send_cell(4'd15, 2'd3);
        send_cell(4'd0,  2'd3);
        send_cell(4'd0,  2'd3);
        send_cell(4'd0,  2'd3);
        send_cell(4'd5,  2'd2);
        send_cell(4'd3,  2'd1);
        send_cell(4'd8,  2'd0);
        send_cell(4'd9,  2'd1);
        send_cell(4'd0,  2'd2);
        send_cell(4'd1,  2'd3);
        send_cell(4'd12, 2'd3);
    endtask

    // Random rows; each phase changes mode mid row after a full drain
    task automatic test_random_rows;
        int remaining;
        int phase_len;
        int phase;
        remaining = RANDOM_ITEMS;
        phase = 0;
        while (remaining > 0) begin
            phase_len = $urandom_range(90, 160);
            if (phase_len > remaining) phase_len = remaining;
            write_mode((phase % 2 == 0) ? MODE_AVERAGE : MODE_HOTTEST);
            no_idle = (phase % 3 == 2);
            repeat (phase_len) send_cell(draw_heat(), t_rnd'($urandom_range(0, 3)));
            no_idle = 1'b0;
            remaining -= phase_len;
            phase++;
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_average_extremes();
        test_hottest_decay();
        test_random_rows();
        drain_rows();
        if (error_count == 0)
            $display("fire_row_stencil regression: pass");
        else
            $display("fire_row_stencil regression: fail");
        $finish;
    end

endmodule

[files.f]
sv/frs_pkg.sv
sv/frs_kernel.sv
sv/frs_queue.sv
sv/fire_row_stencil.sv
sv/frs_checker.sv
sim/tb_fire_row_stencil.sv
